@@ sv/gti_pkg.sv @@
package gti_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int FRACTION_BITS = 8;
   localparam int VALUE_W       = 16;
   localparam int LEVEL_W       = 8;
   localparam int LEVEL_MAX     = 255;

   // last lower bracket index of the scan
   localparam int S_LAST = (LEVEL_MAX - 1 < TABLE_ENTRIES - 2) ? LEVEL_MAX - 1
                                                               : TABLE_ENTRIES - 2;

   // quotient is at most 1.0 in Q1.FRACTION_BITS, one bit per step
   localparam int DIV_STEPS = FRACTION_BITS + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_DIVIDE,
      ST_REPLY
   } state_type;

endpackage

@@ sv/gti_if.sv @@
interface gti_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [gti_pkg::LEVEL_W-1:0] index;
   logic [gti_pkg::VALUE_W-1:0] entry_value;

   modport source (output valid, output command, output index, output entry_value,
                   input ready);
   modport sink (input valid, input command, input index, input entry_value,
                 output ready);
endinterface

interface gti_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gti_pkg::VALUE_W-1:0] inverse_value;
   logic                        found;

   modport source (output valid, output inverse_value, output found, input ready);
   modport sink (input valid, input inverse_value, input found, output ready);
endinterface

@@ sv/gamma_table_inverter.sv @@
// Timing: a write completes in the idle state; a query at level 0 or 255 goes straight to reply,
// other levels go through prime, the scan over brackets and, when needed, the divide before reply.
// Throughput: one request at a time; one table read per cycle, so the scan sets the
// query rate; the reply state waits while a previous response has not been taken.
// Reset (synchronous, active high) clears the sequencer and the response valid flag;
// table contents are undefined until entries are written.
module gamma_table_inverter (
   input logic        clock,
   input logic        reset,
   gti_req_if.sink    req_chan,
   gti_rsp_if.source  rsp_chan
);

   localparam int AW = gti_pkg::ADDR_W;
   localparam int VW = gti_pkg::VALUE_W;
   localparam int FB = gti_pkg::FRACTION_BITS;

   logic [VW-1:0] resp_mem [0:gti_pkg::TABLE_ENTRIES-1];

   gti_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                s_ff, s_in;
   logic [VW-1:0]                target_ff, target_in;
   logic [VW-1:0]                lo_ff, lo_in;
   logic [VW-1:0]                den_ff, den_in;
   logic [VW-1:0]                rem_ff, rem_in;
   logic [gti_pkg::DIV_STEPS-1:0] quo_ff, quo_in;
   logic [gti_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VW-1:0]                res_value_ff, res_value_in;
   logic                         res_found_ff, res_found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                rsp_value_ff, rsp_value_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [VW-1:0]                rd_data_ff;

   logic          req_fire;
   logic          mem_we;
   logic [AW-1:0] rd_addr;
   logic [VW:0]   trial;
   logic          trial_ge;
   logic [VW-1:0] s_scaled;

   assign req_chan.ready = (state_ff == gti_pkg::ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign s_scaled = VW'({s_ff, {FB{1'b0}}});

   // restoring divide: the first step compares the unshifted remainder
   assign trial    = (cnt_ff == gti_pkg::CNT_W'(gti_pkg::DIV_STEPS - 1))
                     ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign trial_ge = trial >= {1'b0, den_ff};

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      target_in    = target_ff;
      lo_in        = lo_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_value_in = res_value_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      mem_we       = 1'b0;
      rd_addr      = AW'(1);

      case (state_ff)
         gti_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.command == gti_pkg::CMD_WRITE) begin
                  mem_we = 1'b1;
               end else if (req_chan.index == '0) begin
                  res_value_in = '0;
                  res_found_in = 1'b1;
                  state_in     = gti_pkg::ST_REPLY;
               end else if (req_chan.index >= gti_pkg::LEVEL_W'(gti_pkg::LEVEL_MAX)) begin
                  res_value_in = VW'(gti_pkg::LEVEL_MAX << FB);
                  res_found_in = 1'b1;
                  state_in     = gti_pkg::ST_REPLY;
               end else begin
                  target_in = VW'({req_chan.index, {FB{1'b0}}});
                  s_in      = AW'(1);
                  state_in  = gti_pkg::ST_PRIME;
               end
            end
         end
         gti_pkg::ST_PRIME: begin
            // rd_data holds table[1]
            lo_in    = rd_data_ff;
            rd_addr  = s_ff + AW'(1);
            state_in = gti_pkg::ST_SCAN;
         end
         gti_pkg::ST_SCAN: begin
            // lo = table[s], rd_data = table[s+1]; prefetch table[s+2]
            rd_addr = s_ff + AW'(2);
            if (lo_ff <= target_ff && rd_data_ff >= target_ff) begin
               den_in = rd_data_ff - lo_ff;
               rem_in = target_ff - lo_ff;
               quo_in = '0;
               cnt_in = gti_pkg::CNT_W'(gti_pkg::DIV_STEPS - 1);
               if (rd_data_ff == lo_ff) begin
                  res_value_in = s_scaled;
                  res_found_in = 1'b1;
                  state_in     = gti_pkg::ST_REPLY;
               end else begin
                  state_in = gti_pkg::ST_DIVIDE;
               end
            end else if (s_ff == AW'(gti_pkg::S_LAST)) begin
               res_value_in = '0;
               res_found_in = 1'b0;
               state_in     = gti_pkg::ST_REPLY;
            end else begin
               s_in  = s_ff + AW'(1);
               lo_in = rd_data_ff;
            end
         end
         gti_pkg::ST_DIVIDE: begin
            rem_in = trial_ge ? VW'(trial - {1'b0, den_ff}) : VW'(trial);
            quo_in = {quo_ff[gti_pkg::DIV_STEPS-2:0], trial_ge};
            cnt_in = cnt_ff - gti_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               res_value_in = s_scaled + VW'(quo_in);
               res_found_in = 1'b1;
               state_in     = gti_pkg::ST_REPLY;
            end
         end
         gti_pkg::ST_REPLY: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_found_in = res_found_ff;
               state_in     = gti_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gti_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         resp_mem[req_chan.index] <= req_chan.entry_value;
      end
      rd_data_ff <= resp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gti_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      target_ff    <= target_in;
      lo_ff        <= lo_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.inverse_value = rsp_value_ff;
   assign rsp_chan.found         = rsp_found_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == gti_pkg::ST_DIVIDE |-> rem_ff <= den_ff && den_ff != '0)
      else $error("divide remainder exceeds divisor");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == gti_pkg::ST_SCAN |-> s_ff >= AW'(1) && s_ff <= AW'(gti_pkg::S_LAST))
      else $error("scan index out of range");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.command == gti_pkg::CMD_QUERY |=> state_ff != gti_pkg::ST_IDLE)
      else $error("query accepted without starting work");

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == gti_pkg::ST_REPLY)
      else $error("response raised outside reply state");

endmodule
